>>> rtl/dbe_pkg.sv
// dbe_pkg: shared types and constants of the dollar-bang escape decoder
// used by dbe_front, dbe_queue, dbe_back and dollar_bang_escape_decoder_core
// no dependencies
package dbe_pkg;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int QUEUE_DEPTH = 4;
   localparam int GROUP_BYTES = 4;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DOLLAR = 3'd1,
      PH_BANG   = 3'd2,
      PH_DIGIT1 = 3'd3,
      PH_DIGIT2 = 3'd4
   } phase_type;

   // decoded bytes caused by one input, count is 1 to 4
   typedef struct packed {
      logic [GROUP_BYTES-1:0][7:0] bytes;
      logic [2:0]                  count;
      logic                        text_end;
   } group_type;

endpackage

>>> rtl/dbe_front.sv
// dbe_front: accepts escaped bytes, tracks the escape phase and builds
// the group of decoded bytes each input causes
// depends on dbe_pkg
module dbe_front import dbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_text_end,
   input  logic       queue_full,
   output logic       push,
   output group_type  group
);

   phase_type  phase_ff, phase_in;
   logic [3:0] first_digit_ff, first_digit_in;
   logic [3:0] second_digit_ff, second_digit_in;
   logic       accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         first_digit_ff  <= 4'd0;
         second_digit_ff <= 4'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         first_digit_ff  <= first_digit_in;
         second_digit_ff <= second_digit_in;
      end
   end

   always_comb begin
      logic [GROUP_BYTES-1:0][7:0] bytes;
      logic [2:0]                  n;
      logic                        fresh;
      logic                        is_dec;
      phase_type                   nxt;
      logic [3:0]                  nf1;
      logic [3:0]                  nf2;
      bytes  = '0;
      n      = 3'd0;
      fresh  = 1'b0;
      is_dec = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
      nxt    = phase_ff;
      nf1    = first_digit_ff;
      nf2    = second_digit_ff;
      case (phase_ff)
         PH_DOLLAR: begin
            if (in_byte == CH_BANG) begin
               nxt = PH_BANG;
            end else begin
               bytes[n[1:0]] = CH_DOLLAR;
               n = n + 3'd1;
               fresh = 1'b1;
            end
         end
         PH_BANG: begin
            if (is_dec) begin
               nf1 = in_byte[3:0];
               nxt = PH_DIGIT1;
            end else begin
               bytes[n[1:0]] = CH_BANG;
               n = n + 3'd1;
               fresh = 1'b1;
            end
         end
         PH_DIGIT1: begin
            if (in_byte == CH_BANG) begin
               bytes[n[1:0]] = {4'h0, first_digit_ff};
               n = n + 3'd1;
               nxt = PH_IDLE;
            end else if (is_dec) begin
               nf2 = in_byte[3:0];
               nxt = PH_DIGIT2;
            end else begin
               bytes[n[1:0]] = CH_BANG;
               n = n + 3'd1;
               bytes[n[1:0]] = {4'h3, first_digit_ff};
               n = n + 3'd1;
               fresh = 1'b1;
            end
         end
         PH_DIGIT2: begin
            if (in_byte == CH_BANG) begin
               // first * 10 + second
               bytes[n[1:0]] = {1'b0, first_digit_ff, 3'b000}
                             + {3'b000, first_digit_ff, 1'b0}
                             + {4'h0, second_digit_ff};
               n = n + 3'd1;
               nxt = PH_IDLE;
            end else begin
               bytes[n[1:0]] = CH_BANG;
               n = n + 3'd1;
               bytes[n[1:0]] = {4'h3, first_digit_ff};
               n = n + 3'd1;
               bytes[n[1:0]] = {4'h3, second_digit_ff};
               n = n + 3'd1;
               fresh = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      if (fresh) begin
         if (in_byte == CH_DOLLAR) begin
            nxt = PH_DOLLAR;
         end else begin
            bytes[n[1:0]] = in_byte;
            n = n + 3'd1;
            nxt = PH_IDLE;
         end
      end

      // end of text flushes whatever is held
      if (in_text_end) begin
         case (nxt)
            PH_DOLLAR: begin
               bytes[n[1:0]] = CH_DOLLAR;
               n = n + 3'd1;
            end
            PH_BANG: begin
               bytes[n[1:0]] = CH_BANG;
               n = n + 3'd1;
            end
            PH_DIGIT1: begin
               bytes[n[1:0]] = CH_BANG;
               n = n + 3'd1;
               bytes[n[1:0]] = {4'h3, nf1};
               n = n + 3'd1;
            end
            PH_DIGIT2: begin
               bytes[n[1:0]] = CH_BANG;
               n = n + 3'd1;
               bytes[n[1:0]] = {4'h3, nf1};
               n = n + 3'd1;
               bytes[n[1:0]] = {4'h3, nf2};
               n = n + 3'd1;
            end
            default: begin
            end
         endcase
         nxt = PH_IDLE;
         nf1 = 4'd0;
         nf2 = 4'd0;
      end

      phase_in        = nxt;
      first_digit_in  = nf1;
      second_digit_in = nf2;
      group.bytes     = bytes;
      group.count     = n;
      group.text_end  = in_text_end;
      push            = accept && (n != 3'd0);
   end

endmodule

>>> rtl/dbe_queue.sv
// dbe_queue: small fifo of decoded byte groups between front and back
// depends on dbe_pkg
module dbe_queue import dbe_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_group,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output group_type head_group
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   group_type       entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_group = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

>>> rtl/dbe_back.sv
// dbe_back: walks the head group byte by byte into the result register
// depends on dbe_pkg
module dbe_back import dbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  group_type  head_group,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_run_last,
   output logic       out_text_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       run_last_ff;
   logic       text_end_ff;
   logic       load;
   logic       is_final;

   assign load     = head_valid && (!valid_ff || out_ready);
   assign is_final = ({1'b0, idx_ff} + 3'd1) == head_group.count;
   assign pop      = load && is_final;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_final ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= head_group.bytes[idx_ff];
         run_last_ff <= is_final;
         text_end_ff <= is_final && head_group.text_end;
      end
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign out_run_last = run_last_ff;
   assign out_text_end = text_end_ff;

endmodule

>>> rtl/dollar_bang_escape_decoder_core.sv
// dollar_bang_escape_decoder_core: top level of the dollar-bang escape decoder
// depends on dbe_pkg, dbe_front, dbe_queue, dbe_back
//
// req channel carries one escaped character per transaction, tlast on the
// final character of a text. rsp channel carries one decoded character per
// transaction: tuser marks the last character caused by a request, tlast the
// final decoded character of the text. "$!d!" and "$!dd!" decode to the byte
// of that value; a '$' not followed by '!' passes as is, and a broken escape
// after "$!" drops the '$' and passes the rest on. The front accepts a
// request whenever the group queue has room and decodes it in that cycle; the
// group goes into the queue, and the back moves it one byte per cycle, while
// rsp_tready is high, into the output register. With one byte out per request
// and rsp_tready high the block takes a request every cycle; one that yields
// several bytes holds the output byte by byte, and the QueueDepth-entry queue
// soaks up such bursts. When rsp_tready is low the output register holds,
// the queue fills and req_tready drops once it is full. Reset empties the
// queue and the output register and returns the decoder to no escape pending.
module dollar_bang_escape_decoder_core import dbe_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] out_run_last
   output logic       rsp_tlast
);

   logic      push;
   group_type push_group;
   logic      full;
   logic      head_valid;
   group_type head_group;
   logic      pop;

   dbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_text_end (req_tlast),
      .queue_full  (full),
      .push        (push),
      .group       (push_group)
   );

   dbe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   dbe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_group   (head_group),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_run_last (rsp_tuser),
      .out_text_end (rsp_tlast)
   );

endmodule
